// ===== rtl/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and range tables shared by the integer text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_WIDTH_SELECT = 8'd0;
  localparam logic [7:0] CFG_SIGNED_MODE  = 8'd1;

  // Reset values of the configuration registers
  localparam logic [1:0] WIDTH_SELECT_RST = 2'd3;
  localparam logic       SIGNED_MODE_RST  = 1'b1;

  // Character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_SIGN  = 2'd1,
    PH_ZERO  = 2'd2,
    PH_DIGIT = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_BIN = 2'd1,
    RX_OCT = 2'd2,
    RX_HEX = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Running state of one string
  typedef struct packed {
    phase_e      phase;
    radix_e      radix;
    logic [63:0] acc;
    logic        neg;
    logic        inv;
    logic        ovf;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase: PH_START,
    radix: RX_DEC,
    acc:   64'd0,
    neg:   1'b0,
    inv:   1'b0,
    ovf:   1'b0
  };

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // Decode a character as a digit of the given radix
  function automatic digit_t digit_decode(logic [7:0] c, radix_e rx);
    digit_t     d;
    logic       is_dig;
    logic [3:0] v;
    logic [7:0] t;
    is_dig = 1'b1;
    t      = 8'd0;
    if (c inside {[CH_0:CH_9]}) begin
      t = c - CH_0;
    end else if (c inside {[CH_LA:CH_LF]}) begin
      t = c - CH_LA + 8'd10;
    end else if (c inside {[CH_UA:CH_UF]}) begin
      t = c - CH_UA + 8'd10;
    end else begin
      is_dig = 1'b0;
    end
    v = t[3:0];
    case (rx)
      RX_BIN:  d.ok = is_dig && (v < 4'd2);
      RX_OCT:  d.ok = is_dig && (v < 4'd8);
      RX_DEC:  d.ok = is_dig && (v < 4'd10);
      default: d.ok = is_dig;
    endcase
    d.val = v;
    return d;
  endfunction

  // Bits that must be clear for an unsigned value of the target width
  function automatic logic [63:0] unsigned_mask(logic [1:0] ws);
    logic [63:0] m;
    case (ws)
      2'd0:    m = 64'hFFFF_FFFF_FFFF_FF00;
      2'd1:    m = 64'hFFFF_FFFF_FFFF_0000;
      2'd2:    m = 64'hFFFF_FFFF_0000_0000;
      default: m = 64'h0000_0000_0000_0000;
    endcase
    return m;
  endfunction

  // Bits that must be clear for a positive signed value of the target width
  function automatic logic [63:0] signed_mask(logic [1:0] ws);
    logic [63:0] m;
    case (ws)
      2'd0:    m = 64'hFFFF_FFFF_FFFF_FF80;
      2'd1:    m = 64'hFFFF_FFFF_FFFF_8000;
      2'd2:    m = 64'hFFFF_FFFF_8000_0000;
      default: m = 64'h8000_0000_0000_0000;
    endcase
    return m;
  endfunction

  // Magnitude of the most negative value of the target width
  function automatic logic [63:0] min_magnitude(logic [1:0] ws);
    logic [63:0] m;
    case (ws)
      2'd0:    m = 64'h0000_0000_0000_0080;
      2'd1:    m = 64'h0000_0000_0000_8000;
      2'd2:    m = 64'h0000_0000_8000_0000;
      default: m = 64'h8000_0000_0000_0000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/itp_step.sv =====
// ----------------------------------------------------------------------------
// itp_step
// Advances the string state by one character: sign, radix prefix and the
// multiply-accumulate of one digit with carry-out detection.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_step (
  input  itp_pkg::parse_state_t st_i,
  input  logic [7:0]            char_code_i,
  input  logic                  char_present_i,
  output itp_pkg::parse_state_t st_o
);

  logic            feed;
  itp_pkg::digit_t dig;
  logic [67:0]     scaled;
  logic [67:0]     prod;

  // Track sign, prefix and radix; mark characters that go to the accumulator
  always_comb begin
    st_o = st_i;
    feed = 1'b0;
    if (char_present_i && !st_i.inv) begin
      case (st_i.phase)
        itp_pkg::PH_START, itp_pkg::PH_SIGN: begin
          if (st_i.phase == itp_pkg::PH_START &&
              (char_code_i == itp_pkg::CH_PLUS || char_code_i == itp_pkg::CH_MINUS)) begin
            st_o.neg   = (char_code_i == itp_pkg::CH_MINUS);
            st_o.phase = itp_pkg::PH_SIGN;
          end else if (char_code_i == itp_pkg::CH_0) begin
            st_o.phase = itp_pkg::PH_ZERO;
          end else begin
            st_o.radix = itp_pkg::RX_DEC;
            st_o.phase = itp_pkg::PH_DIGIT;
            feed       = 1'b1;
          end
        end
        itp_pkg::PH_ZERO: begin
          st_o.phase = itp_pkg::PH_DIGIT;
          if (char_code_i == itp_pkg::CH_LB || char_code_i == itp_pkg::CH_UB) begin
            st_o.radix = itp_pkg::RX_BIN;
          end else if (char_code_i == itp_pkg::CH_LX || char_code_i == itp_pkg::CH_UX) begin
            st_o.radix = itp_pkg::RX_HEX;
          end else if (char_code_i inside {[itp_pkg::CH_0:itp_pkg::CH_7]}) begin
            st_o.radix = itp_pkg::RX_OCT;
            feed       = 1'b1;
          end else begin
            st_o.radix = itp_pkg::RX_DEC;
            feed       = 1'b1;
          end
        end
        default: begin
          feed = 1'b1;
        end
      endcase
    end

    // Scale the accumulator by the radix with shifts
    case (st_o.radix)
      itp_pkg::RX_BIN: scaled = {3'b000, st_i.acc, 1'b0};
      itp_pkg::RX_OCT: scaled = {1'b0, st_i.acc, 3'b000};
      itp_pkg::RX_HEX: scaled = {st_i.acc, 4'b0000};
      default:         scaled = {1'b0, st_i.acc, 3'b000} + {3'b000, st_i.acc, 1'b0};
    endcase

    dig  = itp_pkg::digit_decode(char_code_i, st_o.radix);
    prod = scaled + {64'd0, dig.val};

    // Accumulate one digit, flag a bad digit or a carry past 64 bits
    if (feed) begin
      if (!dig.ok) begin
        st_o.inv = 1'b1;
      end else if (!st_i.ovf) begin
        if (|prod[67:64]) begin
          st_o.ovf = 1'b1;
        end else begin
          st_o.acc = prod[63:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/itp_finish.sv =====
// ----------------------------------------------------------------------------
// itp_finish
// Turns the final string state into a value and a status, checking range
// against the configured width and signedness.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_finish (
  input  itp_pkg::parse_state_t st_i,
  input  logic [1:0]            width_select_i,
  input  logic                  signed_mode_i,
  output logic [63:0]           value_bits_o,
  output itp_pkg::status_e      status_o
);

  logic u_over;
  logic s_over;
  logic at_min;

  assign u_over = |(st_i.acc & itp_pkg::unsigned_mask(width_select_i));
  assign s_over = |(st_i.acc & itp_pkg::signed_mask(width_select_i));
  assign at_min = (st_i.acc == itp_pkg::min_magnitude(width_select_i));

  // Rank the outcomes: empty, invalid, carry-out, then the width check
  always_comb begin
    value_bits_o = 64'd0;
    status_o     = itp_pkg::ST_OK;
    if (st_i.phase == itp_pkg::PH_START) begin
      status_o = itp_pkg::ST_EMPTY;
    end else if (st_i.inv || (st_i.neg && !signed_mode_i)) begin
      status_o = itp_pkg::ST_INVALID;
    end else if (st_i.ovf) begin
      status_o = itp_pkg::ST_RANGE;
    end else if (!signed_mode_i) begin
      if (u_over) begin
        status_o = itp_pkg::ST_RANGE;
      end else begin
        value_bits_o = st_i.acc;
      end
    end else begin
      if (s_over && !(st_i.neg && at_min)) begin
        status_o = itp_pkg::ST_RANGE;
      end else begin
        value_bits_o = st_i.neg ? (64'd0 - st_i.acc) : st_i.acc;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/integer_text_parse.sv =====
// ----------------------------------------------------------------------------
// integer_text_parse
// Streaming parser of one integer string per result word.
// ----------------------------------------------------------------------------
// Characters arrive one word per cycle and the block takes a new word every
// cycle unless a stalled output holds it off. Each word is held in an input
// register, stepped through sign, radix prefix and a single
// multiply-accumulate (shifts and at most two 68-bit adds) into the string
// state, and on the last character the final state is captured and
// range-checked into the output register. A stalled output backs up into
// the final-state and input registers before input ready drops. Width and
// signedness are applied when the result is formed, so write them only while
// the block is idle. A word with char_present low adds nothing; with is_last
// and no earlier character it reports an empty string.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_text_parse (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        char_present_i,
  input  logic        is_last_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_bits_o,
  output logic [1:0]  status_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i
);

  logic [1:0]            width_select_q;
  logic                  signed_mode_q;

  logic                  in_valid_q;
  logic [7:0]            char_q;
  logic                  present_q;
  logic                  last_q;

  itp_pkg::parse_state_t state_q;
  itp_pkg::parse_state_t step_st;

  logic                  fin_valid_q;
  itp_pkg::parse_state_t fin_q;

  logic                  out_valid_q;
  logic [63:0]           value_q;
  logic [1:0]            status_q;

  logic [63:0]           fin_value;
  itp_pkg::status_e      fin_status;

  logic                  out_en;
  logic                  fin_adv;
  logic                  consume;

  // Handshake: each stage moves when the next one is free or moving
  assign out_en      = !out_valid_q || out_ready_i;
  assign fin_adv     = !fin_valid_q || out_en;
  assign consume     = in_valid_q && (!last_q || fin_adv);
  assign in_ready_o  = !in_valid_q || consume;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_select_q <= itp_pkg::WIDTH_SELECT_RST;
      signed_mode_q  <= itp_pkg::SIGNED_MODE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        itp_pkg::CFG_WIDTH_SELECT: width_select_q <= cfg_data_i;
        itp_pkg::CFG_SIGNED_MODE:  signed_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register: hold the word until the step stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q    <= char_code_i;
      present_q <= char_present_i;
      last_q    <= is_last_i;
    end
  end

  itp_step u_step (
    .st_i           (state_q),
    .char_code_i    (char_q),
    .char_present_i (present_q),
    .st_o           (step_st)
  );

  // String state: advance per character, clear after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itp_pkg::STATE_CLEAR;
    end else if (consume) begin
      state_q <= last_q ? itp_pkg::STATE_CLEAR : step_st;
    end
  end

  // Final state of a finished string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (fin_adv) begin
      fin_valid_q <= consume && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_adv && consume && last_q) begin
      fin_q <= step_st;
    end
  end

  itp_finish u_finish (
    .st_i           (fin_q),
    .width_select_i (width_select_q),
    .signed_mode_i  (signed_mode_q),
    .value_bits_o   (fin_value),
    .status_o       (fin_status)
  );

  // Output register: hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && fin_valid_q) begin
      value_q  <= fin_value;
      status_q <= fin_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_bits_o = value_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

// ===== test/tb_integer_text_parse.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_text_parse
// Self-checking testbench for the streaming integer text parser.
// ----------------------------------------------------------------------------
// Character words go in through a valid/ready channel with random gaps, and
// result words are taken with a randomly stalled ready. A model of the parse
// state inside the testbench predicts each result when a last word is
// accepted, and a checker compares every result word with the oldest
// prediction. The run covers the empty, lone sign, bare prefix, octal and
// bad character cases, the range bounds of every width and signedness, and
// random strings in all radixes, some of them corrupted.
// ----------------------------------------------------------------------------

module tb_integer_text_parse;

  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_GAP       = 12;
  localparam int RANDOM_CHARS  = 450;

  typedef struct packed {
    logic [63:0]      value;
    itp_pkg::status_e status;
  } parse_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_code;
  logic        char_present;
  logic        is_last;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] value_bits;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [1:0]  cfg_data;

  // Predicted parse state and register copies
  itp_pkg::phase_e str_phase;
  itp_pkg::radix_e str_radix;
  logic [63:0]     str_acc;
  logic            str_neg;
  logic            str_bad;
  logic            str_carry;
  logic [1:0]      width_sel;
  logic            signed_sel;

  parse_result_t pending_results[$];

  int in_idle_pct;
  int out_idle_pct;
  int mismatches;
  int chars_sent;
  int strings_sent;
  int results_seen;
  int cfg_writes;

  integer_text_parse u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_code_i    (char_code),
    .char_present_i (char_present),
    .is_last_i      (is_last),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .value_bits_o   (value_bits),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // ------------------------------------------------------------------------
  // Parse state prediction
  // ------------------------------------------------------------------------

  function automatic int radix_base(itp_pkg::radix_e rx);
    int b;
    case (rx)
      itp_pkg::RX_BIN: b = 2;
      itp_pkg::RX_OCT: b = 8;
      itp_pkg::RX_HEX: b = 16;
      default:         b = 10;
    endcase
    return b;
  endfunction

  // Hex value of a character, 16 when it is no digit at all
  function automatic int char_digit(logic [7:0] c);
    int d;
    d = 16;
    if (c >= itp_pkg::CH_0 && c <= itp_pkg::CH_9) begin
      d = int'(c - itp_pkg::CH_0);
    end else if (c >= itp_pkg::CH_LA && c <= itp_pkg::CH_LF) begin
      d = c - itp_pkg::CH_LA + 10;
    end else if (c >= itp_pkg::CH_UA && c <= itp_pkg::CH_UF) begin
      d = c - itp_pkg::CH_UA + 10;
    end
    return d;
  endfunction

  task automatic clear_string();
    str_phase = itp_pkg::PH_START;
    str_radix = itp_pkg::RX_DEC;
    str_acc   = 64'd0;
    str_neg   = 1'b0;
    str_bad   = 1'b0;
    str_carry = 1'b0;
  endtask

  // Multiply-accumulate one digit; flag a carry out of 64 bits
  task automatic absorb_digit(input logic [7:0] c);
    int          base;
    int          d;
    logic [67:0] grown;
    base = radix_base(str_radix);
    d    = char_digit(c);
    if (d >= base) begin
      str_bad = 1'b1;
      return;
    end
    if (str_carry) return;
    grown = {4'd0, str_acc} * 68'(base) + 68'(d);
    if (grown[67:64] != 4'd0) str_carry = 1'b1;
    else str_acc = grown[63:0];
  endtask

  task automatic take_char(input logic [7:0] c);
    if (str_bad) return;
    if (str_phase == itp_pkg::PH_START) begin
      if (c == itp_pkg::CH_PLUS || c == itp_pkg::CH_MINUS) begin
        str_neg   = (c == itp_pkg::CH_MINUS);
        str_phase = itp_pkg::PH_SIGN;
        return;
      end
      str_phase = itp_pkg::PH_SIGN;
    end
    if (str_phase == itp_pkg::PH_SIGN) begin
      if (c == itp_pkg::CH_0) begin
        str_phase = itp_pkg::PH_ZERO;
      end else begin
        str_radix = itp_pkg::RX_DEC;
        str_phase = itp_pkg::PH_DIGIT;
        absorb_digit(c);
      end
      return;
    end
    if (str_phase == itp_pkg::PH_ZERO) begin
      str_phase = itp_pkg::PH_DIGIT;
      if (c == itp_pkg::CH_LB || c == itp_pkg::CH_UB) begin
        str_radix = itp_pkg::RX_BIN;
      end else if (c == itp_pkg::CH_LX || c == itp_pkg::CH_UX) begin
        str_radix = itp_pkg::RX_HEX;
      end else if (c >= itp_pkg::CH_0 && c <= itp_pkg::CH_7) begin
        str_radix = itp_pkg::RX_OCT;
        absorb_digit(c);
      end else begin
        str_radix = itp_pkg::RX_DEC;
        absorb_digit(c);
      end
      return;
    end
    absorb_digit(c);
  endtask

  // Form the result of the finished string and queue it
  task automatic close_string();
    parse_result_t r;
    int            w;
    logic [63:0]   min_mag;
    w       = 8 << width_sel;
    min_mag = 64'd1 << (w - 1);
    r.value  = 64'd0;
    r.status = itp_pkg::ST_OK;
    if (str_phase == itp_pkg::PH_START) begin
      r.status = itp_pkg::ST_EMPTY;
    end else if (str_bad || (str_neg && !signed_sel)) begin
      r.status = itp_pkg::ST_INVALID;
    end else if (str_carry) begin
      r.status = itp_pkg::ST_RANGE;
    end else if (!signed_sel) begin
      if (w < 64 && (str_acc >> w) != 64'd0) r.status = itp_pkg::ST_RANGE;
      else r.value = str_acc;
    end else begin
      if (str_acc >= min_mag && !(str_neg && str_acc == min_mag)) begin
        r.status = itp_pkg::ST_RANGE;
      end else begin
        r.value = str_neg ? 64'd0 - str_acc : str_acc;
      end
    end
    pending_results.push_back(r);
    clear_string();
  endtask

  // ------------------------------------------------------------------------
  // Channel drivers
  // ------------------------------------------------------------------------

  // Send one character word; returns at the edge that accepts it
  task automatic send_char(input logic [7:0] code, input logic present,
                           input logic last);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    char_code    <= code;
    char_present <= present;
    is_last      <= last;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    if (present) begin
      chars_sent++;
      take_char(code);
    end
    if (last) begin
      strings_sent++;
      close_string();
    end
  endtask

  task automatic send_text(input string s);
    int n;
    n = s.len();
    if (n == 0) send_char(8'h00, 1'b0, 1'b1);
    for (int i = 0; i < n; i++) send_char(s[i], 1'b1, i == n - 1);
  endtask

  // Drop valid and wait until the block has nothing left in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; valid stays up for a following write
  task automatic write_reg(input logic [7:0] idx, input logic [1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
    cfg_writes++;
    if (idx == itp_pkg::CFG_WIDTH_SELECT) width_sel = data;
    else if (idx == itp_pkg::CFG_SIGNED_MODE) signed_sel = data[0];
  endtask

  task automatic write_config(input logic [1:0] ws, input logic sg);
    write_reg(itp_pkg::CFG_WIDTH_SELECT, ws);
    write_reg(itp_pkg::CFG_SIGNED_MODE, {1'b0, sg});
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sample at the falling edge: the word is taken at the next rising edge
  always @(negedge clk_i) begin
    parse_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", value_bits, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", 64'(status), 64'(want.status));
        if (value_bits !== want.value) report_mismatch("value", value_bits, want.value);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Special strings under the reset setting, 64-bit signed
  task automatic test_special_strings();
    send_char(8'hFF, 1'b0, 1'b1);   // empty string
    send_text("+");
    send_text("-");
    send_text("0x");
    send_text("0B");
    send_text("0");
    send_text("-0");
    send_text("0755");
    send_text("09");
    send_text("0xDeadBEEF");
    send_text("+0b1011");
    send_text("12a");
    send_text("1-2");
    send_text("--1");
    send_text("\t5");
    send_char(8'h00, 1'b1, 1'b1);   // NUL byte alone
    send_char(itp_pkg::CH_0 + 8'd1, 1'b1, 1'b0);
    send_char(8'hFF, 1'b1, 1'b1);
    send_text("0x1g");
    send_text("0b102");
    send_text("18446744073709551616");
    send_text("99999999999999999999x");
    // absent words in the middle and at the end
    send_char(itp_pkg::CH_0 + 8'd4, 1'b1, 1'b0);
    send_char(8'h55, 1'b0, 1'b0);
    send_char(itp_pkg::CH_0 + 8'd2, 1'b1, 1'b1);
    send_char(itp_pkg::CH_7, 1'b1, 1'b0);
    send_char(8'hAA, 1'b0, 1'b1);
    drain();
  endtask

  // Range bounds for every width and signedness
  task automatic test_range_bounds();
    int          w;
    logic [63:0] min_mag;
    logic [63:0] umax;
    for (int ws = 0; ws < 4; ws++) begin
      for (int sg = 0; sg < 2; sg++) begin
        write_config(ws[1:0], sg[0]);
        w       = 8 << ws;
        min_mag = 64'd1 << (w - 1);
        umax    = (w == 64) ? '1 : (64'd1 << w) - 64'd1;
        if (sg == 0) begin
          send_text($sformatf("0x%0h", umax));
          if (w == 64) send_text("0x10000000000000000");
          else send_text($sformatf("0x%0h", umax + 64'd1));
          send_text("-1");
        end else begin
          send_text($sformatf("0x%0h", min_mag - 64'd1));
          send_text($sformatf("0x%0h", min_mag));
          send_text($sformatf("-0x%0h", min_mag));
          send_text($sformatf("-0x%0h", min_mag + 64'd1));
        end
        drain();
      end
    end
  endtask

  // One random string: mostly well formed, some bare, empty or corrupted
  task automatic send_random_string();
    logic [7:0]      txt[$];
    string           s;
    logic [63:0]     mag;
    itp_pkg::radix_e rx;
    int              w;
    int              pick;
    int              n;
    int              pos;
    logic            end_absent;
    pick = $urandom_range(0, 99);
    rx   = itp_pkg::RX_DEC;
    if (pick < 4) begin
      send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    if (pick < 9) begin
      case ($urandom_range(0, 3))
        0:       s = "+";
        1:       s = "-";
        2:       s = "0x";
        default: s = "0b";
      endcase
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        // near a range bound
        w = 8 << $urandom_range(0, 3);
        case ($urandom_range(0, 4))
          0:       mag = (64'd1 << (w - 1)) - 64'd1;
          1:       mag = 64'd1 << (w - 1);
          2:       mag = (64'd1 << (w - 1)) + 64'd1;
          3:       mag = (w == 64) ? '1 : (64'd1 << w) - 64'd1;
          default: mag = (w == 64) ? '1 : 64'd1 << w;
        endcase
      end else begin
        mag = {$urandom, $urandom};
        w   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 20);
        if (w < 64) mag = mag & ((64'd1 << w) - 64'd1);
      end
      rx = itp_pkg::radix_e'($urandom_range(0, 3));
      case (rx)
        itp_pkg::RX_BIN: s = {"0b", $sformatf("%0b", mag)};
        itp_pkg::RX_OCT: s = {"0", $sformatf("%0o", mag)};
        itp_pkg::RX_HEX: s = {"0x", $sformatf("%0h", mag)};
        default:         s = $sformatf("%0d", mag);
      endcase
      // trailing zeros push large values past 64 bits
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) s = {s, "0"};
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) s = {"-", s};
      else if (pick < 45) s = {"+", s};
    end
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    // leading zeros after a binary or hex prefix
    if ((rx == itp_pkg::RX_BIN || rx == itp_pkg::RX_HEX) && $urandom_range(0, 4) == 0) begin
      pos = (txt[0] == itp_pkg::CH_PLUS || txt[0] == itp_pkg::CH_MINUS) ? 3 : 2;
      repeat ($urandom_range(1, 3)) txt.insert(pos, itp_pkg::CH_0);
    end
    // mix letter case of prefixes and hex digits
    foreach (txt[i]) begin
      if ((txt[i] inside {[itp_pkg::CH_LA:itp_pkg::CH_LF]} || txt[i] == itp_pkg::CH_LX) &&
          $urandom_range(0, 1))
        txt[i] = txt[i] - 8'h20;
    end
    // corrupt some strings with stray bytes
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 2)) begin
        pos = $urandom_range(0, txt.size() - 1);
        if ($urandom_range(0, 1)) txt[pos] = 8'($urandom_range(0, 255));
        else txt.insert(pos, 8'($urandom_range(0, 255)));
      end
    end
    n          = txt.size();
    end_absent = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 6) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_char(txt[i], 1'b1, !end_absent && i == n - 1);
    end
    if (end_absent) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Random strings in batches, each batch under a random setting
  task automatic test_random_strings();
    int goal;
    int batch;
    goal  = chars_sent + RANDOM_CHARS;
    batch = 0;
    while (chars_sent < goal) begin
      write_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      // hold a stretch with both sides running flat out
      in_idle_pct  = (batch == 1) ? 0 : 36;
      out_idle_pct = in_idle_pct;
      repeat (12) send_random_string();
      drain();
      batch++;
    end
    in_idle_pct  = 36;
    out_idle_pct = 36;
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    char_code    = 8'd0;
    char_present = 1'b0;
    is_last      = 1'b0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = 8'd0;
    cfg_data     = 2'd0;
    in_idle_pct  = 36;
    out_idle_pct = 36;
    mismatches   = 0;
    chars_sent   = 0;
    strings_sent = 0;
    results_seen = 0;
    cfg_writes   = 0;
    width_sel    = itp_pkg::WIDTH_SELECT_RST;
    signed_sel   = itp_pkg::SIGNED_MODE_RST;
    clear_string();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_strings();
    test_range_bounds();
    test_random_strings();
    drain();

    $display("Sent %0d strings, %0d characters; checked %0d results.",
             strings_sent, chars_sent, results_seen);
    $display("Wrote %0d registers across all widths, signed and unsigned.", cfg_writes);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/itp_pkg.sv
rtl/itp_step.sv
rtl/itp_finish.sv
rtl/integer_text_parse.sv
test/tb_integer_text_parse.sv
